// ===== hw/rtl/i2cm_pkg.sv =====
// shared types and constants for the i2c bit-level master core
// no dependencies; every other rtl file imports this package
package i2cm_pkg;

  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned TICK_W          = 16;
  localparam int unsigned BIT_IDX_W       = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [TICK_W-1:0]    HALF_BIT_RESET = 16'd400;
  localparam logic [BIT_IDX_W-1:0] LAST_BIT       = 4'd7;

  // register indexes
  typedef enum logic [0:0] {
    REG_HALF_BIT = 1'b0
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_STOP_A    = 4'd3,
    PH_WR_LOW    = 4'd4,
    PH_WR_HIGH   = 4'd5,
    PH_WACK_LOW  = 4'd6,
    PH_WACK_HIGH = 4'd7,
    PH_WACK_TAIL = 4'd8,
    PH_RD_LOW    = 4'd9,
    PH_RD_HIGH   = 4'd10,
    PH_MACK_LOW  = 4'd11,
    PH_MACK_HIGH = 4'd12,
    PH_MACK_TAIL = 4'd13
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] opcode;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       slave_nack;
  } out_item_t;

  // classified tick as it sits in the queue
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] write_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_item_t;

  // queue head as seen by the engine
  typedef struct packed {
    logic       valid;
    tick_item_t item;
  } queue_head_t;

endpackage

// ===== hw/rtl/i2c_bit_level_master_core.sv =====
// i2c bit-level master: one input item per bus tick, one result item per input item
// each accepted item is written into the tick queue, then popped by the engine into the result register on out_item
// throughput: one item per cycle while the output does not stall; the engine's sequencer steps once per item
// the tick queue absorbs output stalls for QUEUE_DEPTH items before in_ready drops
// synchronous reset: bus released (scl and sda high), sequencer idle, queue empty,
// half_bit_ticks back to 400
module i2c_bit_level_master_core #(
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  i2cm_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output i2cm_pkg::out_item_t                 out_item,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [i2cm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [i2cm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import i2cm_pkg::*;

  logic [TICK_W-1:0] half_bit_ticks;
  queue_head_t       head;
  logic              pop;
  reg_index_t        reg_sel;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1]);
  assign reg_hit = (reg_sel == REG_HALF_BIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_bit_ticks <= HALF_BIT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      half_bit_ticks <= pwdata[TICK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[TICK_W-1:0] = half_bit_ticks;
    end
  end

  i2cm_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .pop      (pop),
    .head     (head)
  );

  i2cm_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .half_bit_ticks (half_bit_ticks),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item)
  );

  // a finishing tick always leaves the sequencer idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> !out_item.busy_res)
    else $error("done result still reports busy");

  // a command cannot finish on two ticks in a row
  a_no_double_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_item.done_res |=> !(out_valid && out_item.done_res))
    else $error("two finishing ticks back to back");

  // reset empties the result register and the tick queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

// ===== hw/rtl/i2cm_queue.sv =====
// small fifo of classified ticks between front and engine
// depends on i2cm_pkg for the entry type
module i2cm_queue #(
  parameter int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  i2cm_pkg::tick_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output i2cm_pkg::queue_head_t head
);
  import i2cm_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tick_item_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_FULL);
  assign do_push = push && !full;
  assign do_pop  = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/i2cm_front.sv =====
// front end: takes input ticks, decodes the command and queues them
// depends on i2cm_pkg and i2cm_queue
module i2cm_front #(
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2cm_pkg::in_item_t    in_item,
  input  logic                  pop,
  output i2cm_pkg::queue_head_t head
);
  import i2cm_pkg::*;

  tick_item_t classified;
  logic       full;

  always_comb begin
    classified.write_byte = in_item.write_byte;
    classified.send_ack   = in_item.send_ack;
    classified.sda_in     = in_item.sda_in;
    if (!in_item.cmd_valid) begin
      classified.kind = CMD_NONE;
    end else begin
      unique case (opcode_t'(in_item.opcode))
        OP_START: classified.kind = CMD_START;
        OP_STOP:  classified.kind = CMD_STOP;
        OP_WRITE: classified.kind = CMD_WRITE;
        OP_READ:  classified.kind = CMD_READ;
        default:  classified.kind = CMD_NONE;
      endcase
    end
  end

  assign in_ready = !full;

  i2cm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_item (classified),
    .pop       (pop),
    .full      (full),
    .head      (head)
  );

endmodule

// ===== hw/rtl/i2cm_engine.sv =====
// back end: bus sequencer that plays out one tick per cycle unless the output stalls, with output register
// depends on i2cm_pkg
module i2cm_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [i2cm_pkg::TICK_W-1:0]   half_bit_ticks,
  input  i2cm_pkg::queue_head_t         head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output i2cm_pkg::out_item_t           out_item
);
  import i2cm_pkg::*;

  phase_t               phase, phase_next;
  logic [BIT_IDX_W-1:0] bit_index, bit_index_next;
  logic [TICK_W-1:0]    tick_count, tick_count_next;
  logic [7:0]           shift_byte, shift_byte_next;
  logic                 ack_to_send, ack_to_send_next;
  logic                 nack_flag, nack_flag_next;
  logic                 scl_reg, scl_reg_next;
  logic                 sda_reg, sda_reg_next;
  logic [7:0]           rx_hold, rx_hold_next;
  logic                 done;

  logic [TICK_W-1:0]    limit;
  logic [TICK_W:0]      tick_plus;
  logic                 busy;
  logic                 seg_end;
  logic [7:0]           rd_shift;
  logic                 last_bit;
  tick_item_t           t;

  assign t         = head.item;
  assign pop       = head.valid && (!out_valid || out_ready);
  assign limit     = (half_bit_ticks == '0) ? TICK_W'(1) : half_bit_ticks;
  assign tick_plus = {1'b0, tick_count} + 1'b1;
  assign busy      = (phase != PH_IDLE);
  assign seg_end   = busy && (tick_plus >= {1'b0, limit});
  assign rd_shift  = {shift_byte[6:0], t.sda_in};
  assign last_bit  = (bit_index >= LAST_BIT);

  // next state
  always_comb begin
    phase_next = phase;
    done       = 1'b0;
    if (!busy) begin
      unique case (t.kind)
        CMD_START: phase_next = PH_START_A;
        CMD_STOP:  phase_next = PH_STOP_A;
        CMD_WRITE: phase_next = PH_WR_LOW;
        CMD_READ:  phase_next = PH_RD_LOW;
        default:   phase_next = PH_IDLE;
      endcase
    end else if (seg_end) begin
      unique case (phase)
        PH_START_A:   phase_next = PH_START_B;
        PH_START_B:   begin phase_next = PH_IDLE; done = 1'b1; end
        PH_STOP_A:    begin phase_next = PH_IDLE; done = 1'b1; end
        PH_WR_LOW:    phase_next = PH_WR_HIGH;
        PH_WR_HIGH:   phase_next = last_bit ? PH_WACK_LOW : PH_WR_LOW;
        PH_WACK_LOW:  phase_next = PH_WACK_HIGH;
        PH_WACK_HIGH: phase_next = PH_WACK_TAIL;
        PH_WACK_TAIL: begin phase_next = PH_IDLE; done = 1'b1; end
        PH_RD_LOW:    phase_next = PH_RD_HIGH;
        PH_RD_HIGH:   phase_next = last_bit ? PH_MACK_LOW : PH_RD_LOW;
        PH_MACK_LOW:  phase_next = PH_MACK_HIGH;
        PH_MACK_HIGH: phase_next = PH_MACK_TAIL;
        PH_MACK_TAIL: begin phase_next = PH_IDLE; done = 1'b1; end
        default:      phase_next = PH_IDLE;
      endcase
    end
  end

  // drive levels and datapath
  always_comb begin
    bit_index_next   = bit_index;
    tick_count_next  = tick_count;
    shift_byte_next  = shift_byte;
    ack_to_send_next = ack_to_send;
    nack_flag_next   = nack_flag;
    scl_reg_next     = scl_reg;
    sda_reg_next     = sda_reg;
    rx_hold_next     = rx_hold;
    if (!busy) begin
      if (t.kind != CMD_NONE) begin
        bit_index_next  = '0;
        tick_count_next = '0;
      end
      unique case (t.kind)
        CMD_START: begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
        CMD_STOP:  begin scl_reg_next = 1'b1; sda_reg_next = 1'b0; end
        CMD_WRITE: begin
          shift_byte_next = t.write_byte;
          scl_reg_next    = 1'b0;
          sda_reg_next    = t.write_byte[7];
        end
        CMD_READ: begin
          shift_byte_next  = '0;
          ack_to_send_next = t.send_ack;
          scl_reg_next     = 1'b0;
          sda_reg_next     = 1'b1;
        end
        default: ;
      endcase
    end else if (!seg_end) begin
      tick_count_next = tick_plus[TICK_W-1:0];
    end else begin
      tick_count_next = '0;
      unique case (phase)
        PH_START_A:   begin scl_reg_next = 1'b1; sda_reg_next = 1'b0; end
        PH_START_B:   begin scl_reg_next = 1'b0; sda_reg_next = 1'b0; end
        PH_STOP_A:    begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
        PH_WR_LOW:    scl_reg_next = 1'b1;
        PH_WR_HIGH: begin
          scl_reg_next = 1'b0;
          if (last_bit) begin
            sda_reg_next = 1'b1;
          end else begin
            bit_index_next  = bit_index + 1'b1;
            shift_byte_next = {shift_byte[6:0], 1'b0};
            sda_reg_next    = shift_byte[6];
          end
        end
        PH_WACK_LOW:  begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
        PH_WACK_HIGH: begin
          nack_flag_next = t.sda_in;
          scl_reg_next   = 1'b0;
          sda_reg_next   = 1'b1;
        end
        PH_WACK_TAIL: begin scl_reg_next = 1'b0; sda_reg_next = 1'b1; end
        PH_RD_LOW:    begin scl_reg_next = 1'b1; sda_reg_next = 1'b1; end
        PH_RD_HIGH: begin
          shift_byte_next = rd_shift;
          scl_reg_next    = 1'b0;
          if (last_bit) begin
            rx_hold_next = rd_shift;
            sda_reg_next = !ack_to_send;
          end else begin
            bit_index_next = bit_index + 1'b1;
            sda_reg_next   = 1'b1;
          end
        end
        PH_MACK_LOW:  scl_reg_next = 1'b1;
        PH_MACK_HIGH: scl_reg_next = 1'b0;
        PH_MACK_TAIL: scl_reg_next = 1'b0;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_index   <= '0;
      tick_count  <= '0;
      shift_byte  <= '0;
      ack_to_send <= 1'b0;
      nack_flag   <= 1'b0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      rx_hold     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        bit_index   <= bit_index_next;
        tick_count  <= tick_count_next;
        shift_byte  <= shift_byte_next;
        ack_to_send <= ack_to_send_next;
        nack_flag   <= nack_flag_next;
        scl_reg     <= scl_reg_next;
        sda_reg     <= sda_reg_next;
        rx_hold     <= rx_hold_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded with the state after this tick
  always_ff @(posedge clk) begin
    if (pop) begin
      out_item.scl_level  <= scl_reg_next;
      out_item.sda_level  <= sda_reg_next;
      out_item.busy_res   <= (phase_next != PH_IDLE);
      out_item.done_res   <= done;
      out_item.read_byte  <= rx_hold_next;
      out_item.slave_nack <= nack_flag_next;
    end
  end

endmodule

// ===== dv/tb.sv =====
// testbench for the i2c bit-level master core: self-checking, with a tick-accurate bus predictor
// depends on i2cm_pkg and i2c_bit_level_master_core; drives items and apb writes, checks every result
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  i2c_bit_level_master_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // bus sequencer state as predicted
  logic [15:0] half_bit;
  phase_t seq_phase;
  logic [3:0] bit_idx;
  logic [15:0] seg_ticks;
  logic [7:0] shreg;
  logic ack_bit;
  logic nack_seen;
  logic scl_q;
  logic sda_q;
  logic [7:0] rx_byte;

  out_item_t bus_expect[$];
  out_item_t want_item;
  int fail_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic void seg_enter(phase_t p, logic c, logic d);
    seq_phase = p;
    scl_q = c;
    sda_q = d;
    seg_ticks = '0;
  endfunction

  function automatic out_item_t bus_tick(in_item_t it);
    logic [16:0] nxt;
    logic [15:0] lim;
    logic fin;
    out_item_t r;
    lim = (half_bit == 16'd0) ? 16'd1 : half_bit;
    fin = 1'b0;
    if (seq_phase == PH_IDLE) begin
      if (it.cmd_valid) begin
        bit_idx = '0;
        case (opcode_t'(it.opcode))
          OP_START: seg_enter(PH_START_A, 1'b1, 1'b1);
          OP_STOP:  seg_enter(PH_STOP_A, 1'b1, 1'b0);
          OP_WRITE: begin
            shreg = it.write_byte;
            seg_enter(PH_WR_LOW, 1'b0, it.write_byte[7]);
          end
          default: begin
            shreg = '0;
            ack_bit = it.send_ack;
            seg_enter(PH_RD_LOW, 1'b0, 1'b1);
          end
        endcase
      end
    end else begin
      nxt = {1'b0, seg_ticks} + 17'd1;
      if (nxt >= {1'b0, lim}) begin
        // segment over: move to the next drive levels
        case (seq_phase)
          PH_START_A: seg_enter(PH_START_B, 1'b1, 1'b0);
          PH_START_B: begin
            seg_enter(PH_IDLE, 1'b0, 1'b0);
            fin = 1'b1;
          end
          PH_STOP_A: begin
            seg_enter(PH_IDLE, 1'b1, 1'b1);
            fin = 1'b1;
          end
          PH_WR_LOW: seg_enter(PH_WR_HIGH, 1'b1, sda_q);
          PH_WR_HIGH: begin
            if (bit_idx >= LAST_BIT) begin
              seg_enter(PH_WACK_LOW, 1'b0, 1'b1);
            end else begin
              bit_idx = bit_idx + 4'd1;
              shreg = {shreg[6:0], 1'b0};
              seg_enter(PH_WR_LOW, 1'b0, shreg[7]);
            end
          end
          PH_WACK_LOW: seg_enter(PH_WACK_HIGH, 1'b1, 1'b1);
          PH_WACK_HIGH: begin
            nack_seen = it.sda_in;
            seg_enter(PH_WACK_TAIL, 1'b0, 1'b1);
          end
          PH_WACK_TAIL: begin
            seg_enter(PH_IDLE, 1'b0, 1'b1);
            fin = 1'b1;
          end
          PH_RD_LOW: seg_enter(PH_RD_HIGH, 1'b1, 1'b1);
          PH_RD_HIGH: begin
            shreg = {shreg[6:0], it.sda_in};
            if (bit_idx >= LAST_BIT) begin
              rx_byte = shreg;
              seg_enter(PH_MACK_LOW, 1'b0, ~ack_bit);
            end else begin
              bit_idx = bit_idx + 4'd1;
              seg_enter(PH_RD_LOW, 1'b0, 1'b1);
            end
          end
          PH_MACK_LOW:  seg_enter(PH_MACK_HIGH, 1'b1, sda_q);
          PH_MACK_HIGH: seg_enter(PH_MACK_TAIL, 1'b0, sda_q);
          PH_MACK_TAIL: begin
            seg_enter(PH_IDLE, 1'b0, sda_q);
            fin = 1'b1;
          end
          default: seq_phase = PH_IDLE;
        endcase
      end else begin
        seg_ticks = nxt[15:0];
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res = (seq_phase != PH_IDLE);
    r.done_res = fin;
    r.read_byte = rx_byte;
    r.slave_nack = nack_seen;
    return r;
  endfunction

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) note_fail($sformatf("%s expected %0h got %0h", name, want, got));
  endfunction

  // result checker: sampled at the falling edge, the item moves at the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (bus_expect.size() == 0) begin
        note_fail("result with nothing expected");
      end else begin
        want_item = bus_expect.pop_front();
        check_field("scl_level", 32'(want_item.scl_level), 32'(out_item.scl_level));
        check_field("sda_level", 32'(want_item.sda_level), 32'(out_item.sda_level));
        check_field("busy_res", 32'(want_item.busy_res), 32'(out_item.busy_res));
        check_field("done_res", 32'(want_item.done_res), 32'(out_item.done_res));
        check_field("read_byte", 32'(want_item.read_byte), 32'(out_item.read_byte));
        check_field("slave_nack", 32'(want_item.slave_nack), 32'(out_item.slave_nack));
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_tick(in_item_t it);
    logic rdy;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    bus_expect.push_back(bus_tick(it));
  endtask

  function automatic in_item_t pick_tick(int cmd_pct);
    in_item_t it;
    it.opcode = 2'($urandom);
    it.write_byte = 8'($urandom);
    it.send_ack = 1'($urandom);
    it.sda_in = 1'($urandom);
    // mostly well-formed: commands while idle, rare ignored ones while busy
    if (seq_phase == PH_IDLE) it.cmd_valid = ($urandom_range(99) < cmd_pct);
    else it.cmd_valid = ($urandom_range(99) < 15);
    return it;
  endfunction

  task automatic idle_ticks(int n);
    repeat (n) send_tick(pick_tick(0));
  endtask

  // play one command to its end; sda_mode 0 low, 1 high, 2 random
  task automatic run_cmd(opcode_t op, logic [7:0] b, logic ack, int sda_mode, bit pester);
    in_item_t it;
    it.cmd_valid = 1'b1;
    it.opcode = op;
    it.write_byte = b;
    it.send_ack = ack;
    it.sda_in = (sda_mode == 2) ? 1'($urandom) : sda_mode[0];
    send_tick(it);
    while (seq_phase != PH_IDLE) begin
      it.cmd_valid = pester;
      it.opcode = 2'($urandom);
      it.write_byte = 8'($urandom);
      it.send_ack = 1'($urandom);
      it.sda_in = (sda_mode == 2) ? 1'($urandom) : sda_mode[0];
      send_tick(it);
    end
  endtask

  // finish any command in flight, then drain all results
  task automatic settle();
    while (seq_phase != PH_IDLE) send_tick(pick_tick(0));
    in_valid <= 1'b0;
    while (bus_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    logic rdy;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= APB_ADDR_W'(4 * int'(REG_HALF_BIT));
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      rdata = prdata;
      @(posedge clk);
    end while (!rdy);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_half_bit();
    logic [31:0] rd;
    apb_access(1'b0, 32'd0, rd);
    check_field("half_bit_ticks", 32'(half_bit), 32'(rd[15:0]));
  endtask

  task automatic set_half_bit(logic [15:0] h);
    logic [31:0] rd;
    // upper bits are don't-care for a 16-bit register
    apb_access(1'b1, {16'($urandom), h}, rd);
    half_bit = h;
    check_half_bit();
  endtask

  task automatic set_idling(int g, int s);
    gap_pct = g;
    stall_pct = s;
  endtask

  task automatic test_reset_timing();
    check_half_bit();
    idle_ticks(8);
    settle();
  endtask

  task automatic test_zero_half_bit();
    set_half_bit(16'd0);
    run_cmd(OP_START, 8'h00, 1'b0, 2, 1'b0);
    run_cmd(OP_WRITE, 8'hFF, 1'b0, 0, 1'b0);
    run_cmd(OP_WRITE, 8'h00, 1'b1, 1, 1'b1);
    run_cmd(OP_READ, 8'h5A, 1'b1, 1, 1'b0);
    run_cmd(OP_READ, 8'hA5, 1'b0, 0, 1'b1);
    idle_ticks(3);
    run_cmd(OP_STOP, 8'hFF, 1'b1, 2, 1'b1);
    settle();
  endtask

  task automatic test_one_half_bit();
    set_half_bit(16'd1);
    run_cmd(OP_START, 8'hFF, 1'b1, 1, 1'b1);
    run_cmd(OP_WRITE, 8'hA5, 1'b0, 2, 1'b0);
    run_cmd(OP_READ, 8'h00, 1'b1, 2, 1'b1);
    run_cmd(OP_STOP, 8'h00, 1'b0, 0, 1'b0);
    settle();
  endtask

  // largest setting: register readback and idle ticks only, no command is run
  task automatic test_max_half_bit();
    set_half_bit(16'hFFFF);
    idle_ticks(4);
    settle();
  endtask

  task automatic test_random(int g, int s, logic [15:0] h, int n);
    set_idling(g, s);
    set_half_bit(h);
    repeat (n) send_tick(pick_tick(75));
    settle();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    set_half_bit(16'd1);
    @(negedge clk);
    hold_asked++;
    @(posedge clk);
    repeat (100) send_tick(pick_tick(75));
    settle();
  endtask

  initial begin
    half_bit = HALF_BIT_RESET;
    seq_phase = PH_IDLE;
    bit_idx = '0;
    seg_ticks = '0;
    shreg = '0;
    ack_bit = 1'b0;
    nack_seen = 1'b0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    rx_byte = '0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_timing();
    test_zero_half_bit();
    test_one_half_bit();
    test_max_half_bit();
    test_random(0, 0, 16'd1, 110);
    test_random(71, 0, 16'd2, 110);
    test_random(0, 71, 16'd3, 110);
    test_random(27, 27, 16'd1, 110);
    test_backpressure();

    while (bus_expect.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (bus_expect.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_queue.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_engine.sv
hw/rtl/i2c_bit_level_master_core.sv
dv/tb.sv
